FILE: hw/rtl/tcw_pkg.sv
package tcw_pkg;

	// Fixed field widths and limits of the block.
	localparam int MAX_WINDOW = 1024;
	localparam int FRAC_BITS = 8;
	localparam int WIN_W = 11;
	localparam int INIT_W = 19;
	localparam int GAIN_W = 16;
	localparam int LF_W = 9;
	localparam int PROD_W = WIN_W + LF_W;
	localparam int INC_W = GAIN_W - FRAC_BITS + 1;
	localparam int CLAMP_W = 13;
	localparam int CNT_W = 4;
	localparam int IDX_W = 2;

	localparam logic [WIN_W-1:0] THRESH_UNSET = WIN_W'(MAX_WINDOW + 1);
	localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(MAX_WINDOW);
	localparam logic [WIN_W-1:0] WIN_ONE = WIN_W'(1);

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_INITIAL_WINDOW = 2'd0;
	localparam logic [IDX_W-1:0] REG_SLOW_START_GAIN = 2'd1;
	localparam logic [IDX_W-1:0] REG_AVOIDANCE_GAIN = 2'd2;
	localparam logic [IDX_W-1:0] REG_LOSS_FACTOR = 2'd3;

	// Operation of the serial arithmetic unit.
	typedef enum logic {
		OP_MUL,
		OP_DIV
	} tcw_op_t;

	// Command to the serial unit.
	typedef struct packed {
		logic             start;
		tcw_op_t          op;
		logic [WIN_W-1:0] a;
		logic [WIN_W-1:0] b;
	} tcw_ctl_t;

	// Status back from the serial unit.
	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] result;
	} tcw_sts_t;

	// Clamp a window value into the range one to the maximum window.
	function automatic logic [WIN_W-1:0] clamp_win(input logic [CLAMP_W-1:0] v);
		logic [WIN_W-1:0] r;
		if (v == '0) begin
			r = WIN_ONE;
		end else if (v > CLAMP_W'(MAX_WINDOW)) begin
			r = WIN_MAX;
		end else begin
			r = v[WIN_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/tcw_round_if.sv
interface tcw_round_if;
	logic valid;
	logic ready;
	logic ack_missed;

	modport source (output valid, output ack_missed, input ready);
	modport sink (input valid, input ack_missed, output ready);
endinterface

FILE: hw/rtl/tcw_update_if.sv
interface tcw_update_if;
	import tcw_pkg::*;

	logic             valid;
	logic             ready;
	logic [WIN_W-1:0] window;
	logic             in_linear_phase;
	logic [WIN_W-1:0] threshold;

	modport source (output valid, output window, output in_linear_phase, output threshold,
		input ready);
	modport sink (input valid, input window, input in_linear_phase, input threshold,
		output ready);
endinterface

FILE: hw/rtl/tcp_congestion_window_update.sv
// Congestion window update, one round per input beat.
// The rounds channel carries ack_missed: 1 for a lost ACK, 0 for a received one.
// The updates channel returns one beat per round: the new window, the phase
// flag (1 = linear avoidance) and the slow-start threshold (1025 = unset).
// The configuration port writes one register per cycle; the user is bound to
// write only while the block is idle, which the block itself does not enforce.
// Writing initial_window reloads the window with its ceiling, clamped to 1..1024.
// A received ACK in slow start needs no serial step; a received ACK in avoidance
// runs the 11-step serial divider and a missed ACK the 9-step serial shift-add
// multiplier. One round is in work at a time: a new round is taken only after
// the last one has left its final step.
// A finished result waits in the output register while the next round is taken;
// if the receiver stalls with a result still waiting, the round after that
// holds in its final step until the register frees up.
// Reset gives window 1, threshold unset, slow-start phase, and register values
// 256, 256, 256 and 128.
module tcp_congestion_window_update (
	input  logic                     clk,
	input  logic                     arst_n,
	tcw_round_if.sink                rounds,
	tcw_update_if.source             updates,
	input  logic                     cfg_wen,
	input  logic [tcw_pkg::IDX_W-1:0]  cfg_index,
	input  logic [tcw_pkg::INIT_W-1:0] cfg_wdata
);
	import tcw_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		KIND_MISS,
		KIND_EXP,
		KIND_LIN
	} kind_t;

	state_t            state_q;
	kind_t             kind_q;
	logic [WIN_W-1:0]  win_q;
	logic [WIN_W-1:0]  thr_q;
	logic              lin_q;
	logic [GAIN_W-1:0] ssg_q;
	logic [GAIN_W-1:0] ag_q;
	logic [LF_W-1:0]   lf_q;
	tcw_ctl_t          ctl_q;
	logic              out_valid_q;
	logic [WIN_W-1:0]  out_win_q;
	logic              out_lin_q;
	logic [WIN_W-1:0]  out_thr_q;

	tcw_sts_t          sts;
	logic [INC_W-1:0]  ss_inc;
	logic [INC_W-1:0]  av_ceil;
	logic [WIN_W-1:0]  div_num;
	logic [PROD_W:0]   prod_round;
	logic [WIN_W-1:0]  win_next;
	logic [WIN_W-1:0]  thr_next;
	logic              lin_next;
	logic [INIT_W:0]   init_round;
	logic              out_free;

	tcw_serial_unit u_serial (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_q),
		.sts    (sts)
	);

	// Ceilings of the gains, the divider numerator for the avoidance step, and rounding of the initial window and product.
	always_comb begin
		ss_inc = INC_W'(({1'b0, ssg_q} + (GAIN_W + 1)'((1 << FRAC_BITS) - 1)) >> FRAC_BITS);
		av_ceil = INC_W'(({1'b0, ag_q} + (GAIN_W + 1)'((1 << FRAC_BITS) - 1)) >> FRAC_BITS);
		div_num = WIN_W'(CLAMP_W'(av_ceil) + CLAMP_W'(win_q) - CLAMP_W'(1));
		init_round = ({1'b0, cfg_wdata} + (INIT_W + 1)'((1 << FRAC_BITS) - 1));
		prod_round = ({1'b0, sts.result} + (PROD_W + 1)'((1 << FRAC_BITS) - 1));
	end

	// New state at the end of a round.
	always_comb begin
		win_next = win_q;
		thr_next = thr_q;
		lin_next = lin_q;
		unique case (kind_q)
			KIND_MISS: begin
				thr_next = win_q >> 1;
				win_next = clamp_win(CLAMP_W'(prod_round >> FRAC_BITS));
				lin_next = !(win_next < thr_next);
			end
			KIND_EXP: begin
				win_next = clamp_win(CLAMP_W'(win_q) + CLAMP_W'(ss_inc));
				lin_next = (win_next >= thr_q);
			end
			KIND_LIN: begin
				win_next = clamp_win(CLAMP_W'(win_q) + CLAMP_W'(sts.result[WIN_W-1:0]));
			end
			default: begin
				win_next = win_q;
			end
		endcase
	end

	assign out_free = !out_valid_q || updates.ready;

	// Sequencer, round state, configuration registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= KIND_EXP;
			win_q <= WIN_ONE;
			thr_q <= THRESH_UNSET;
			lin_q <= 1'b0;
			ssg_q <= GAIN_W'(256);
			ag_q <= GAIN_W'(256);
			lf_q <= LF_W'(128);
			ctl_q <= '0;
			out_valid_q <= 1'b0;
			out_win_q <= '0;
			out_lin_q <= 1'b0;
			out_thr_q <= '0;
		end else begin
			// The output beat is raised when a round finishes and dropped once taken.
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && updates.ready) begin
				out_valid_q <= 1'b0;
			end

			// The user must make configuration writes only while idle; the block does not enforce it.
			if (cfg_wen) begin
				unique case (cfg_index)
					REG_INITIAL_WINDOW: win_q <= clamp_win(CLAMP_W'(init_round >> FRAC_BITS));
					REG_SLOW_START_GAIN: ssg_q <= cfg_wdata[GAIN_W-1:0];
					REG_AVOIDANCE_GAIN: ag_q <= cfg_wdata[GAIN_W-1:0];
					REG_LOSS_FACTOR: lf_q <= cfg_wdata[LF_W-1:0];
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (rounds.valid) begin
						if (rounds.ack_missed) begin
							kind_q <= KIND_MISS;
							ctl_q <= '{start: 1'b1, op: OP_MUL, a: win_q, b: WIN_W'(lf_q)};
							state_q <= ST_RUN;
						end else if (!lin_q) begin
							kind_q <= KIND_EXP;
							ctl_q.start <= 1'b0;
							state_q <= ST_FIN;
						end else begin
							kind_q <= KIND_LIN;
							ctl_q <= '{start: 1'b1, op: OP_DIV, a: div_num, b: win_q};
							state_q <= ST_RUN;
						end
					end else begin
						ctl_q.start <= 1'b0;
					end
				end
				ST_RUN: begin
					ctl_q.start <= 1'b0;
					if (sts.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					ctl_q.start <= 1'b0;
					if (out_free) begin
						win_q <= win_next;
						thr_q <= thr_next;
						lin_q <= lin_next;
						out_win_q <= win_next;
						out_lin_q <= lin_next;
						out_thr_q <= thr_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					ctl_q.start <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rounds.ready = (state_q == ST_IDLE);
	assign updates.valid = out_valid_q;
	assign updates.window = out_win_q;
	assign updates.in_linear_phase = out_lin_q;
	assign updates.threshold = out_thr_q;

endmodule

FILE: hw/rtl/tcw_serial_unit.sv
module tcw_serial_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  tcw_pkg::tcw_ctl_t ctl,
	output tcw_pkg::tcw_sts_t sts
);
	import tcw_pkg::*;

	tcw_op_t           op_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] acc_q;
	logic [LF_W-1:0]   mreg_q;
	logic [WIN_W-1:0]  md_q;
	logic [WIN_W-1:0]  rem_q;
	logic [WIN_W-1:0]  nreg_q;
	logic [WIN_W-1:0]  dreg_q;

	logic [WIN_W:0]    trial;
	logic              qbit;
	logic [CNT_W-1:0]  last;

	// One restoring division step: bring down the next numerator bit.
	always_comb begin
		trial = {rem_q, nreg_q[WIN_W-1]};
		qbit = (trial >= {1'b0, dreg_q});
		last = (op_q == OP_MUL) ? CNT_W'(LF_W - 1) : CNT_W'(WIN_W - 1);
	end

	// Control of the iteration count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				op_q <= ctl.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift-add multiply or restoring divide, one bit per cycle.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
			md_q <= ctl.a;
			mreg_q <= ctl.b[LF_W-1:0];
			rem_q <= '0;
			nreg_q <= ctl.a;
			dreg_q <= ctl.b;
		end else if (busy_q) begin
			unique case (op_q)
				OP_MUL: begin
					acc_q <= {acc_q[PROD_W-2:0], 1'b0}
						+ (mreg_q[LF_W-1] ? PROD_W'(md_q) : '0);
					mreg_q <= {mreg_q[LF_W-2:0], 1'b0};
				end
				OP_DIV: begin
					rem_q <= qbit ? WIN_W'(trial - {1'b0, dreg_q}) : trial[WIN_W-1:0];
					nreg_q <= {nreg_q[WIN_W-2:0], qbit};
				end
			endcase
		end
	end

	assign sts.done = done_q;
	assign sts.result = (op_q == OP_MUL) ? acc_q : PROD_W'(nreg_q);

endmodule

FILE: tb/tcw_window_checker.sv
`timescale 1ns / 100ps

// Watches the rounds and updates channels and the configuration port, keeps its own
// copy of the congestion state, and compares every update beat with the oldest
// predicted one.
module tcw_window_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	tcw_round_if                       rounds,
	tcw_update_if                      updates,
	input  logic                       cfg_wen,
	input  logic [tcw_pkg::IDX_W-1:0]  cfg_index,
	input  logic [tcw_pkg::INIT_W-1:0] cfg_wdata,
	output int unsigned                mismatches,
	output int unsigned                outstanding
);
	import tcw_pkg::*;

	// Window, phase and threshold after a round, as carried by one update beat.
	typedef struct packed {
		logic [WIN_W-1:0] window;
		logic             in_linear_phase;
		logic [WIN_W-1:0] threshold;
	} window_state_t;

	logic [INIT_W-1:0] init_window_q8;
	logic [GAIN_W-1:0] slow_start_q8;
	logic [GAIN_W-1:0] avoidance_q8;
	logic [LF_W-1:0]   loss_q8;
	window_state_t     congestion;
	window_state_t     predicted_updates[$];
	int unsigned       fail_total;

	// Round a Q.8 value up to the next whole segment.
	function automatic logic [31:0] ceil_segments(input logic [31:0] q8);
		return (q8 + (32'd1 << FRAC_BITS) - 32'd1) >> FRAC_BITS;
	endfunction

	// Keep a window between one segment and the maximum window.
	function automatic logic [WIN_W-1:0] bound_window(input logic [31:0] w);
		if (w == 32'd0) begin
			return WIN_ONE;
		end else if (w > 32'(MAX_WINDOW)) begin
			return WIN_MAX;
		end
		return w[WIN_W-1:0];
	endfunction

	// State after one round, for a lost or a received ACK.
	function automatic window_state_t next_round(input window_state_t cur, input logic missed);
		window_state_t nxt;
		logic [31:0]   den;
		logic [31:0]   step;
		nxt = cur;
		if (missed) begin
			nxt.threshold = cur.window >> 1;
			nxt.window = bound_window(ceil_segments(32'(loss_q8) * 32'(cur.window)));
			nxt.in_linear_phase = !(nxt.window < nxt.threshold);
		end else if (!cur.in_linear_phase) begin
			nxt.window = bound_window(32'(cur.window) + ceil_segments(32'(slow_start_q8)));
			if (nxt.window >= cur.threshold) begin
				nxt.in_linear_phase = 1'b1;
			end
		end else begin
			den = 32'(cur.window) << FRAC_BITS;
			step = (32'(avoidance_q8) + den - 32'd1) / den;
			nxt.window = bound_window(32'(cur.window) + step);
		end
		return nxt;
	endfunction

	// Compare update beats first, since a beat leaving at the same edge as a round
	// arrives always belongs to an earlier round; then predict, then track writes.
	always @(posedge clk or negedge arst_n) begin : round_monitor
		window_state_t got;
		window_state_t want;
		if (!arst_n) begin
			init_window_q8 = INIT_W'(256);
			slow_start_q8 = GAIN_W'(256);
			avoidance_q8 = GAIN_W'(256);
			loss_q8 = LF_W'(128);
			congestion.window = bound_window(ceil_segments(32'(init_window_q8)));
			congestion.in_linear_phase = 1'b0;
			congestion.threshold = THRESH_UNSET;
			predicted_updates.delete();
			fail_total = 0;
		end else begin
			if (updates.valid && updates.ready) begin
				got.window = updates.window;
				got.in_linear_phase = updates.in_linear_phase;
				got.threshold = updates.threshold;
				if (predicted_updates.size() == 0) begin
					$error("update beat with no round waiting: window %0d", got.window);
					fail_total++;
				end else begin
					want = predicted_updates.pop_front();
					if (got.window !== want.window) begin
						$error("window: expected %0d, got %0d", want.window, got.window);
						fail_total++;
					end
					if (got.in_linear_phase !== want.in_linear_phase) begin
						$error("in_linear_phase: expected %0d, got %0d",
							want.in_linear_phase, got.in_linear_phase);
						fail_total++;
					end
					if (got.threshold !== want.threshold) begin
						$error("threshold: expected %0d, got %0d",
							want.threshold, got.threshold);
						fail_total++;
					end
				end
			end
			if (rounds.valid && rounds.ready) begin
				congestion = next_round(congestion, rounds.ack_missed);
				predicted_updates.push_back(congestion);
			end
			if (cfg_wen) begin
				case (cfg_index)
					REG_INITIAL_WINDOW: begin
						init_window_q8 = cfg_wdata;
						congestion.window = bound_window(ceil_segments(32'(init_window_q8)));
					end
					REG_SLOW_START_GAIN: begin
						slow_start_q8 = cfg_wdata[GAIN_W-1:0];
					end
					REG_AVOIDANCE_GAIN: begin
						avoidance_q8 = cfg_wdata[GAIN_W-1:0];
					end
					REG_LOSS_FACTOR: begin
						loss_q8 = cfg_wdata[LF_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
		mismatches <= fail_total;
		outstanding <= predicted_updates.size();
	end

endmodule

FILE: tb/tcp_congestion_window_update_tb.sv
`timescale 1ns / 100ps

module tcp_congestion_window_update_tb;
	import tcw_pkg::*;

	localparam logic ROUND_ACKED = 1'b0;
	localparam logic ROUND_LOST = 1'b1;
	localparam int unsigned RANDOM_ROUNDS_PER_MODE = 584;

	logic              clk;
	logic              arst_n;
	logic              cfg_wen;
	logic [IDX_W-1:0]  cfg_index;
	logic [INIT_W-1:0] cfg_wdata;
	int unsigned       mismatches;
	int unsigned       outstanding;
	int unsigned       send_idle_pct;
	int unsigned       recv_idle_pct;

	tcw_round_if  rounds ();
	tcw_update_if updates ();

	tcp_congestion_window_update i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rounds    (rounds),
		.updates   (updates),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	tcw_window_checker i_window_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.rounds      (rounds),
		.updates     (updates),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The receiver stalls at random, at the rate of the current mode.
	always @(negedge clk) begin
		updates.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	// Offer one round beat, after a random gap, and hold it until it is taken.
	task automatic send_round(input logic missed);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			rounds.valid <= 1'b0;
			@(negedge clk);
		end
		rounds.valid <= 1'b1;
		rounds.ack_missed <= missed;
		do begin
			@(posedge clk);
		end while (!rounds.ready);
	endtask

	// Stop sending and wait until every predicted update has come back.
	task automatic drain();
		int unsigned guard;
		guard = 0;
		@(negedge clk);
		rounds.valid <= 1'b0;
		while (outstanding != 0 && guard < 100_000) begin
			@(negedge clk);
			guard++;
		end
		repeat (16) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [INIT_W-1:0] data);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// A register value: extremes and reset values now and then, mostly values that
	// keep the window moving. Narrow registers get junk in their unused upper bits.
	function automatic logic [INIT_W-1:0] pick_setting(input logic [IDX_W-1:0] idx);
		logic [INIT_W-1:0] value;
		logic [INIT_W-1:0] junk;
		int unsigned       pick;
		pick = $urandom_range(9);
		junk = INIT_W'($urandom_range(2 ** INIT_W - 1));
		case (idx)
			REG_INITIAL_WINDOW: begin
				case (pick)
					0: value = '0;
					1: value = '1;
					2: value = INIT_W'(256);
					3, 4, 5: value = INIT_W'($urandom_range(16 * 256));
					default: value = INIT_W'($urandom_range(MAX_WINDOW * 256));
				endcase
				junk = '0;
			end
			REG_SLOW_START_GAIN, REG_AVOIDANCE_GAIN: begin
				case (pick)
					0: value = '0;
					1: value = INIT_W'(2 ** GAIN_W - 1);
					2: value = INIT_W'(256);
					3, 4, 5: value = INIT_W'($urandom_range(1024));
					default: value = INIT_W'($urandom_range(2 ** GAIN_W - 1));
				endcase
				junk[GAIN_W-1:0] = '0;
			end
			default: begin
				case (pick)
					0: value = '0;
					1: value = INIT_W'(2 ** LF_W - 1);
					2: value = INIT_W'(128);
					3: value = INIT_W'($urandom_range(2 ** LF_W - 1));
					default: value = INIT_W'($urandom_range(64, 256));
				endcase
				junk[LF_W-1:0] = '0;
			end
		endcase
		if ($urandom_range(1) == 0) begin
			junk = '0;
		end
		return value | junk;
	endfunction

	initial begin
		int unsigned sent;
		int unsigned burst;
		int unsigned loss_pct;
		arst_n = 1'b0;
		rounds.valid = 1'b0;
		rounds.ack_missed = ROUND_ACKED;
		cfg_wen = 1'b0;
		cfg_index = REG_INITIAL_WINDOW;
		cfg_wdata = '0;
		send_idle_pct = 8;
		recv_idle_pct = 63;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Slow start from reset, threshold still unset.
		send_round(ROUND_ACKED);
		send_round(ROUND_ACKED);

		// A zero initial window gives one segment; a loss there sets a threshold of zero.
		drain();
		write_reg(REG_INITIAL_WINDOW, '0);
		send_round(ROUND_LOST);
		send_round(ROUND_ACKED);
		send_round(ROUND_ACKED);

		// Largest gains, a loss factor of one, and an initial window past the limit.
		drain();
		write_reg(REG_SLOW_START_GAIN, INIT_W'(2 ** GAIN_W - 1));
		write_reg(REG_AVOIDANCE_GAIN, INIT_W'(2 ** GAIN_W - 1));
		write_reg(REG_LOSS_FACTOR, INIT_W'(256));
		write_reg(REG_INITIAL_WINDOW, '1);
		send_round(ROUND_ACKED);
		send_round(ROUND_LOST);
		send_round(ROUND_ACKED);

		// A loss factor above one makes the window grow on each loss.
		drain();
		write_reg(REG_INITIAL_WINDOW, INIT_W'(256));
		write_reg(REG_LOSS_FACTOR, INIT_W'(2 ** LF_W - 1));
		send_round(ROUND_LOST);
		send_round(ROUND_LOST);
		send_round(ROUND_LOST);
		send_round(ROUND_ACKED);

		// A zero avoidance gain holds the window; a zero loss factor drops it to one.
		drain();
		write_reg(REG_LOSS_FACTOR, '0);
		write_reg(REG_AVOIDANCE_GAIN, '0);
		send_round(ROUND_ACKED);
		send_round(ROUND_LOST);
		send_round(ROUND_ACKED);

		// A deep cut from the full window goes back to slow start, here with no gain.
		drain();
		write_reg(REG_INITIAL_WINDOW, '1);
		write_reg(REG_LOSS_FACTOR, INIT_W'(1));
		write_reg(REG_SLOW_START_GAIN, '0);
		send_round(ROUND_LOST);
		send_round(ROUND_ACKED);
		send_round(ROUND_ACKED);

		// Slow start with the largest gain crosses the threshold into avoidance.
		drain();
		write_reg(REG_SLOW_START_GAIN, INIT_W'(2 ** GAIN_W - 1));
		send_round(ROUND_ACKED);
		send_round(ROUND_ACKED);
		send_round(ROUND_ACKED);

		// Random bursts of rounds, each after a random set of register writes and with its own
		// loss rate, through the three idling modes.
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 8;
					recv_idle_pct = 63;
				end
				1: begin
					send_idle_pct = 63;
					recv_idle_pct = 8;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < RANDOM_ROUNDS_PER_MODE) begin
				drain();
				for (int r = 0; r < 4; r++) begin
					if ($urandom_range(1) != 0) begin
						write_reg(IDX_W'(r), pick_setting(IDX_W'(r)));
					end
				end
				burst = $urandom_range(10, 60);
				loss_pct = $urandom_range(3, 40);
				repeat (burst) begin
					send_round($urandom_range(99) < loss_pct);
					sent++;
				end
			end
		end

		drain();
		if (outstanding != 0) begin
			$error("%0d update beats never arrived", outstanding);
		end
		if (mismatches == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
